@@ src/pair_field_grid_convolution_assert.svh @@
`ifndef PAIR_FIELD_GRID_CONVOLUTION_ASSERT_SVH
`define PAIR_FIELD_GRID_CONVOLUTION_ASSERT_SVH

// same-cycle implication
`define PFGC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfgc: implication check failed");

// next-cycle implication
`define PFGC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfgc: next-cycle check failed");

`endif

@@ src/pfgc_pkg.sv @@
package pfgc_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam int COORD_W    = 6;
   localparam int VALUE_W    = 32;
   localparam int PHI_W      = 48;
   localparam int SIZE_REG_W = 7;
   localparam int AREA_W     = 32;
   localparam int PROD_W     = 64;
   localparam int LANES      = 4;

   localparam int DEF_ACC_W = PROD_W + $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT);

   localparam int REQ_DATA_W  = 112;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 208;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [SIZE_REG_W-1:0] RST_GRID_WIDTH  = 7'd64;
   localparam logic [SIZE_REG_W-1:0] RST_GRID_HEIGHT = 7'd64;
   localparam logic [AREA_W-1:0]     RST_CELL_AREA   = 32'h0001_0000;

   localparam logic [PHI_W-1:0] PHI_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [PHI_W-1:0] PHI_MIN = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      ACT_LOAD_DENSITY   = 2'd0,
      ACT_LOAD_POTENTIAL = 2'd1,
      ACT_COMPUTE        = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH   = 3'd0,
      CSR_GRID_HEIGHT  = 3'd1,
      CSR_WALL_X       = 3'd2,
      CSR_WALL_Y       = 3'd3,
      CSR_CELL_AREA    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_SCALE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       mac_valid;
      logic       scale_valid;
      logic [1:0] scale_step;
   } ctrl_type;

endpackage

@@ src/pfgc_ram.sv @@
module pfgc_ram
   #(
      parameter int WIDTH = 32,
      parameter int DEPTH = 4096
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/pfgc_seq.sv @@
`include "pair_field_grid_convolution_assert.svh"

module pfgc_seq
   import pfgc_pkg::*;
   #(
      parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
      parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
   )
   (
      input  logic                                  clock,
      input  logic                                  reset,
      input  logic                                  req_fire,
      input  logic [1:0]                            req_action,
      input  logic [COORD_W-1:0]                    req_cell_x,
      input  logic [COORD_W-1:0]                    req_cell_y,
      input  logic [SIZE_REG_W-1:0]                 grid_width,
      input  logic [SIZE_REG_W-1:0]                 grid_height,
      input  logic                                  wall_x,
      input  logic                                  wall_y,
      input  logic                                  out_free,
      output logic                                  req_ready,
      output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] src_addr,
      output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] tab_addr,
      output ctrl_type                              ctrl,
      output logic                                  load_out,
      output logic [COORD_W-1:0]                    out_x,
      output logic [COORD_W-1:0]                    out_y
   );

   localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int XCW = $clog2(MAX_WIDTH + 1);
   localparam int YCW = $clog2(MAX_HEIGHT + 1);
   localparam int OW  = (XCW > YCW) ? XCW : YCW;

   function automatic logic [OW-1:0] axis_offset(input logic [OW-1:0] i,
                                                 input logic [OW-1:0] j,
                                                 input logic [OW-1:0] n,
                                                 input logic          walled);
      logic [OW-1:0] d;
      if (i >= j) begin
         d = i - j;
      end else if (walled) begin
         d = j - i;
      end else begin
         d = i + n - j;
      end
      if (!walled && (d > (n >> 1))) begin
         d = n - d;
      end
      return d;
   endfunction

   state_type            state_ff, state_in;
   logic [XW-1:0]        jx_ff, jx_in;
   logic [YW-1:0]        jy_ff, jy_in;
   logic [XW-1:0]        tx_ff, tx_in;
   logic [YW-1:0]        ty_ff, ty_in;
   logic [COORD_W-1:0]   out_x_ff, out_x_in;
   logic [COORD_W-1:0]   out_y_ff, out_y_in;
   logic [2:0]           tick_ff, tick_in;
   logic                 rd_valid_ff;
   logic                 rd_valid;
   logic                 clear;
   logic                 scale_valid;
   logic [1:0]           scale_step;
   logic [XCW-1:0]       w_size;
   logic [YCW-1:0]       h_size;
   logic [OW-1:0]        dx, dy;

   always_comb begin
      w_size = (grid_width == '0) ? XCW'(1) :
               ((int'(grid_width) > MAX_WIDTH) ? XCW'(MAX_WIDTH) : XCW'(grid_width));
      h_size = (grid_height == '0) ? YCW'(1) :
               ((int'(grid_height) > MAX_HEIGHT) ? YCW'(MAX_HEIGHT) : YCW'(grid_height));
      dx = axis_offset(OW'(tx_ff), OW'(jx_ff), OW'(w_size), wall_x);
      dy = axis_offset(OW'(ty_ff), OW'(jy_ff), OW'(h_size), wall_y);
      src_addr = AW'(int'(jy_ff) * MAX_WIDTH + int'(jx_ff));
      tab_addr = AW'(int'(dy) * MAX_WIDTH + int'(dx));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         jx_ff       <= '0;
         jy_ff       <= '0;
         tick_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         jx_ff       <= jx_in;
         jy_ff       <= jy_in;
         tick_ff     <= tick_in;
         rd_valid_ff <= rd_valid;
      end
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
   end

   always_comb begin
      state_in    = state_ff;
      jx_in       = jx_ff;
      jy_in       = jy_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      tick_in     = tick_ff;
      rd_valid    = 1'b0;
      clear       = 1'b0;
      scale_valid = 1'b0;
      scale_step  = tick_ff[1:0];
      load_out    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_COMPUTE) &&
                (int'(req_cell_x) < int'(w_size)) && (int'(req_cell_y) < int'(h_size))) begin
               tx_in    = XW'(req_cell_x);
               ty_in    = YW'(req_cell_y);
               out_x_in = req_cell_x;
               out_y_in = req_cell_y;
               jx_in    = '0;
               jy_in    = '0;
               clear    = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid = 1'b1;
            if (int'(jx_ff) + 1 == int'(w_size)) begin
               jx_in = '0;
               if (int'(jy_ff) + 1 == int'(h_size)) begin
                  tick_in  = '0;
                  state_in = ST_DRAIN;
               end else begin
                  jy_in = jy_ff + YW'(1);
               end
            end else begin
               jx_in = jx_ff + XW'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last products to land in the accumulators
            tick_in = tick_ff + 3'd1;
            if (tick_ff == 3'd2) begin
               tick_in  = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // three limb passes, then wait for the last scaled products to land
            scale_valid = (tick_ff < 3'd3);
            tick_in     = tick_ff + 3'd1;
            if (tick_ff == 3'd4) begin
               tick_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign ctrl.clear       = clear;
   assign ctrl.mac_valid   = rd_valid_ff;
   assign ctrl.scale_valid = scale_valid;
   assign ctrl.scale_step  = scale_step;
   assign out_x            = out_x_ff;
   assign out_y            = out_y_ff;

   `PFGC_ASSERT_IMP(a_unit_exclusive, clock, reset, ctrl.mac_valid, !ctrl.scale_valid)
   `PFGC_ASSERT_IMP(a_load_when_free, clock, reset, load_out, out_free)
   `PFGC_ASSERT_IMP(a_scan_in_grid, clock, reset, rd_valid, (int'(jx_ff) < int'(w_size)) && (int'(jy_ff) < int'(h_size)))
   `PFGC_ASSERT_NXT(a_clear_starts_scan, clock, reset, ctrl.clear, state_ff == ST_SCAN)

endmodule

@@ src/pfgc_mac.sv @@
module pfgc_mac
   import pfgc_pkg::*;
   #(
      parameter int ACC_W = DEF_ACC_W
   )
   (
      input  logic                         clock,
      input  ctrl_type                     ctrl,
      input  logic [AREA_W-1:0]            cell_area,
      input  logic signed [VALUE_W-1:0]    rho_one,
      input  logic signed [VALUE_W-1:0]    rho_two,
      input  logic signed [VALUE_W-1:0]    u_same_first,
      input  logic signed [VALUE_W-1:0]    u_cross,
      input  logic signed [VALUE_W-1:0]    u_same_second,
      input  logic                         reset,
      output logic [LANES-1:0][PHI_W-1:0]  phi
   );

   localparam int OP_W = VALUE_W + 1;
   localparam int PW   = 2 * OP_W;
   localparam int SC_W = ACC_W + AREA_W;

   logic signed [VALUE_W-1:0] lane_rho [LANES];
   logic signed [VALUE_W-1:0] lane_u   [LANES];
   logic signed [OP_W-1:0]    op_a     [LANES];
   logic signed [OP_W-1:0]    op_b     [LANES];
   logic signed [PW-1:0]      prod_ff  [LANES];
   logic signed [ACC_W-1:0]   acc_ff   [LANES];
   logic signed [SC_W-1:0]    sc_ff    [LANES];
   logic                      p_mac_ff;
   logic                      p_scale_ff;
   logic [1:0]                p_step_ff;

   always_comb begin
      lane_rho[0] = rho_one;
      lane_rho[1] = rho_two;
      lane_rho[2] = rho_one;
      lane_rho[3] = rho_two;
      lane_u[0]   = u_same_first;
      lane_u[1]   = u_cross;
      lane_u[2]   = u_cross;
      lane_u[3]   = u_same_second;
      for (int k = 0; k < LANES; k++) begin
         if (ctrl.scale_valid) begin
            op_b[k] = $signed({1'b0, cell_area});
            unique case (ctrl.scale_step)
               2'd0:    op_a[k] = $signed({1'b0, acc_ff[k][31:0]});
               2'd1:    op_a[k] = $signed({1'b0, acc_ff[k][63:32]});
               default: op_a[k] = OP_W'($signed(acc_ff[k][ACC_W-1:PROD_W]));
            endcase
         end else begin
            op_a[k] = OP_W'(lane_rho[k]);
            op_b[k] = OP_W'(lane_u[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_mac_ff   <= 1'b0;
         p_scale_ff <= 1'b0;
      end else begin
         p_mac_ff   <= ctrl.mac_valid;
         p_scale_ff <= ctrl.scale_valid;
      end
      p_step_ff <= ctrl.scale_step;
      for (int k = 0; k < LANES; k++) begin
         prod_ff[k] <= op_a[k] * op_b[k];
         if (ctrl.clear) begin
            acc_ff[k] <= '0;
            sc_ff[k]  <= '0;
         end else begin
            if (p_mac_ff) begin
               acc_ff[k] <= acc_ff[k] + ACC_W'(prod_ff[k]);
            end
            if (p_scale_ff) begin
               sc_ff[k] <= sc_ff[k] + (SC_W'(prod_ff[k]) <<< {p_step_ff, 5'd0});
            end
         end
      end
   end

   // Q60.48 down to Q32.16, floor, then clamp to 48 bits
   always_comb begin
      logic [ACC_W-1:0] v;
      for (int k = 0; k < LANES; k++) begin
         v = sc_ff[k][SC_W-1:AREA_W];
         if ((v[ACC_W-1:PHI_W-1] == '0) || (v[ACC_W-1:PHI_W-1] == '1)) begin
            phi[k] = v[PHI_W-1:0];
         end else begin
            phi[k] = v[ACC_W-1] ? PHI_MIN : PHI_MAX;
         end
      end
   end

endmodule

@@ src/pair_field_grid_convolution.sv @@
// Direct 2-D convolution of two species density grids with three symmetric
// interaction tables (U11, U12, U22). Beats with tuser 0 or 1 load one cell of
// the densities or of the tables and return nothing. A beat with tuser 2
// computes one target cell: the block walks every source cell of the grid in
// use, one read of each store and one set of four 32x32 multiply-accumulates
// per cycle, over the single read port of each store. req_tready is low during
// a compute. The result sits in an output register, so loads and the next
// compute are taken while it waits. Offsets are absolute on a walled axis and
// minimum-image on a periodic one. Sums are exact, scaled by cell_area and
// saturated to signed 48-bit Q32.16. The stores are not cleared: a cell read
// before it was loaded gives an undefined result. Write the configuration only
// while the block is idle.
module pair_field_grid_convolution
   import pfgc_pkg::*;
   #(
      parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
      parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
   )
   (
      input  logic                   clock,
      input  logic                   reset,
      input  logic                   req_tvalid,
      output logic                   req_tready,
      // cell_x, cell_y, value_one, value_two, value_three, zero pad
      input  logic [REQ_DATA_W-1:0]  req_tdata,
      // action
      input  logic [REQ_USER_W-1:0]  req_tuser,
      output logic                   rsp_tvalid,
      input  logic                   rsp_tready,
      // out_x, out_y, phi_one_one, phi_one_two, phi_two_one, phi_two_two, zero pad
      output logic [RSP_DATA_W-1:0]  rsp_tdata,
      input  logic                   csr_valid,
      output logic                   csr_ready,
      input  logic [CSR_INDEX_W-1:0] csr_index,
      input  logic [CSR_DATA_W-1:0]  csr_data
   );

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int ACC_W = PROD_W + AW;

   logic [SIZE_REG_W-1:0] grid_width_ff, grid_width_in;
   logic [SIZE_REG_W-1:0] grid_height_ff, grid_height_in;
   logic                  wall_x_ff, wall_x_in;
   logic                  wall_y_ff, wall_y_in;
   logic [AREA_W-1:0]     cell_area_ff, cell_area_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [1:0]            action;
   logic [COORD_W-1:0]    cell_x, cell_y;
   logic [VALUE_W-1:0]    value_one, value_two, value_three;
   logic                  req_fire;
   logic                  in_store;
   logic [AW-1:0]         wr_addr;
   logic                  dens_we, pot_we;
   logic [AW-1:0]         src_addr, tab_addr;
   logic [VALUE_W-1:0]    rho_one, rho_two, u_same_first, u_cross, u_same_second;
   ctrl_type              ctrl;
   logic                  load_out;
   logic                  out_free;
   logic [COORD_W-1:0]    out_x, out_y;
   logic [LANES-1:0][PHI_W-1:0] phi;

   assign action      = req_tuser[1:0];
   assign cell_x      = req_tdata[5:0];
   assign cell_y      = req_tdata[11:6];
   assign value_one   = req_tdata[43:12];
   assign value_two   = req_tdata[75:44];
   assign value_three = req_tdata[107:76];

   assign req_fire = req_tvalid && req_tready;
   assign in_store = (int'(cell_x) < MAX_WIDTH) && (int'(cell_y) < MAX_HEIGHT);
   assign wr_addr  = AW'(int'(cell_y) * MAX_WIDTH + int'(cell_x));
   assign dens_we  = req_fire && in_store && (action == ACT_LOAD_DENSITY);
   assign pot_we   = req_fire && in_store && (action == ACT_LOAD_POTENTIAL);

   assign csr_ready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      wall_x_in      = wall_x_ff;
      wall_y_in      = wall_y_ff;
      cell_area_in   = cell_area_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_data[SIZE_REG_W-1:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_data[SIZE_REG_W-1:0];
            CSR_WALL_X:      wall_x_in      = csr_data[0];
            CSR_WALL_Y:      wall_y_in      = csr_data[0];
            CSR_CELL_AREA:   cell_area_in   = csr_data[AREA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = load_out ? {4'd0, phi, out_y, out_x} : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= RST_GRID_WIDTH;
         grid_height_ff <= RST_GRID_HEIGHT;
         wall_x_ff      <= 1'b0;
         wall_y_ff      <= 1'b0;
         cell_area_ff   <= RST_CELL_AREA;
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         wall_x_ff      <= wall_x_in;
         wall_y_ff      <= wall_y_in;
         cell_area_ff   <= cell_area_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pfgc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_density_first (
      .clock   (clock),
      .wr_en   (dens_we),
      .wr_addr (wr_addr),
      .wr_data (value_one),
      .rd_addr (src_addr),
      .rd_data (rho_one)
   );

   pfgc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_density_second (
      .clock   (clock),
      .wr_en   (dens_we),
      .wr_addr (wr_addr),
      .wr_data (value_two),
      .rd_addr (src_addr),
      .rd_data (rho_two)
   );

   pfgc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_potential_same_first (
      .clock   (clock),
      .wr_en   (pot_we),
      .wr_addr (wr_addr),
      .wr_data (value_one),
      .rd_addr (tab_addr),
      .rd_data (u_same_first)
   );

   pfgc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_potential_cross (
      .clock   (clock),
      .wr_en   (pot_we),
      .wr_addr (wr_addr),
      .wr_data (value_two),
      .rd_addr (tab_addr),
      .rd_data (u_cross)
   );

   pfgc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_potential_same_second (
      .clock   (clock),
      .wr_en   (pot_we),
      .wr_addr (wr_addr),
      .wr_data (value_three),
      .rd_addr (tab_addr),
      .rd_data (u_same_second)
   );

   pfgc_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_action  (action),
      .req_cell_x  (cell_x),
      .req_cell_y  (cell_y),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .wall_x      (wall_x_ff),
      .wall_y      (wall_y_ff),
      .out_free    (out_free),
      .req_ready   (req_tready),
      .src_addr    (src_addr),
      .tab_addr    (tab_addr),
      .ctrl        (ctrl),
      .load_out    (load_out),
      .out_x       (out_x),
      .out_y       (out_y)
   );

   pfgc_mac #(.ACC_W(ACC_W)) u_mac (
      .clock         (clock),
      .ctrl          (ctrl),
      .cell_area     (cell_area_ff),
      .rho_one       (rho_one),
      .rho_two       (rho_two),
      .u_same_first  (u_same_first),
      .u_cross       (u_cross),
      .u_same_second (u_same_second),
      .reset         (reset),
      .phi           (phi)
   );

endmodule

@@ bench/tb_pair_field_grid_convolution.sv @@
`timescale 1ns / 1ps

module tb_pair_field_grid_convolution;
   import pfgc_pkg::*;

   localparam int CELLS          = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int LONG_HOLD      = 600;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [REQ_USER_W-1:0]  ACT_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE  = 3'd5;

   typedef struct packed {
      logic [COORD_W-1:0]        out_x;
      logic [COORD_W-1:0]        out_y;
      logic [3:0][PHI_W-1:0]     phi;
   } phi_beat_type;

   class phi_tracker_type;
      logic [SIZE_REG_W-1:0] width_reg;
      logic [SIZE_REG_W-1:0] height_reg;
      logic                  wall_x;
      logic                  wall_y;
      logic [AREA_W-1:0]     area;
      logic signed [VALUE_W-1:0] rho_one [CELLS];
      logic signed [VALUE_W-1:0] rho_two [CELLS];
      logic signed [VALUE_W-1:0] u_one_one [CELLS];
      logic signed [VALUE_W-1:0] u_cross [CELLS];
      logic signed [VALUE_W-1:0] u_two_two [CELLS];
      phi_beat_type phi_pending [$];
      int errors;

      function new();
         width_reg  = RST_GRID_WIDTH;
         height_reg = RST_GRID_HEIGHT;
         wall_x     = 1'b0;
         wall_y     = 1'b0;
         area       = RST_CELL_AREA;
         errors     = 0;
      endfunction

      function int span(logic [SIZE_REG_W-1:0] r, int limit);
         if (r == 0) return 1;
         return (r > limit) ? limit : int'(r);
      endfunction

      function int offset(int i, int j, int n, logic walled);
         int d;
         if (walled) return (i >= j) ? i - j : j - i;
         d = (i + n - j) % n;
         if (d > n / 2) d = n - d;
         return d;
      endfunction

      function logic signed [127:0] widen(logic signed [VALUE_W-1:0] v);
         return v;
      endfunction

      function logic [PHI_W-1:0] scale_phi(logic signed [127:0] s);
         logic signed [127:0] p;
         p = (s * $signed({96'd0, area})) >>> 32;
         if (p > 128'sh7FFF_FFFF_FFFF) return PHI_MAX;
         if (p < -128'sh8000_0000_0000) return PHI_MIN;
         return p[PHI_W-1:0];
      endfunction

      function phi_beat_type phi_for_cell(int tx, int ty);
         int w, h, dx, dy, src, tab;
         logic signed [127:0] s11, s12, s21, s22;
         phi_beat_type r;
         w = span(width_reg, DEF_MAX_WIDTH);
         h = span(height_reg, DEF_MAX_HEIGHT);
         s11 = '0;
         s12 = '0;
         s21 = '0;
         s22 = '0;
         for (int jy = 0; jy < h; jy++) begin
            dy = offset(ty, jy, h, wall_y);
            for (int jx = 0; jx < w; jx++) begin
               dx = offset(tx, jx, w, wall_x);
               src = jy * DEF_MAX_WIDTH + jx;
               tab = dy * DEF_MAX_WIDTH + dx;
               s11 += widen(rho_one[src]) * widen(u_one_one[tab]);
               s12 += widen(rho_two[src]) * widen(u_cross[tab]);
               s21 += widen(rho_one[src]) * widen(u_cross[tab]);
               s22 += widen(rho_two[src]) * widen(u_two_two[tab]);
            end
         end
         r.out_x  = tx[COORD_W-1:0];
         r.out_y  = ty[COORD_W-1:0];
         r.phi[0] = scale_phi(s11);
         r.phi[1] = scale_phi(s12);
         r.phi[2] = scale_phi(s21);
         r.phi[3] = scale_phi(s22);
         return r;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GRID_WIDTH:  width_reg  = data[SIZE_REG_W-1:0];
            CSR_GRID_HEIGHT: height_reg = data[SIZE_REG_W-1:0];
            CSR_WALL_X:      wall_x     = data[0];
            CSR_WALL_Y:      wall_y     = data[0];
            CSR_CELL_AREA:   area       = data;
            default: ;
         endcase
      endfunction

      function void take_request(logic [REQ_USER_W-1:0] act, logic [COORD_W-1:0] x,
                                 logic [COORD_W-1:0] y, logic [VALUE_W-1:0] v1,
                                 logic [VALUE_W-1:0] v2, logic [VALUE_W-1:0] v3);
         int slot;
         slot = int'(y) * DEF_MAX_WIDTH + int'(x);
         case (act)
            ACT_LOAD_DENSITY: begin
               rho_one[slot] = v1;
               rho_two[slot] = v2;
            end
            ACT_LOAD_POTENTIAL: begin
               u_one_one[slot] = v1;
               u_cross[slot]   = v2;
               u_two_two[slot] = v3;
            end
            ACT_COMPUTE: begin
               if (x < span(width_reg, DEF_MAX_WIDTH) && y < span(height_reg, DEF_MAX_HEIGHT))
                  phi_pending.push_back(phi_for_cell(int'(x), int'(y)));
            end
            default: ;
         endcase
      endfunction

      function void check_field(string name, logic [PHI_W-1:0] want, logic [PHI_W-1:0] got);
         if (got !== want) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_phi(logic [RSP_DATA_W-1:0] d);
         phi_beat_type want;
         phi_beat_type got;
         got.out_x = d[5:0];
         got.out_y = d[11:6];
         for (int k = 0; k < 4; k++) got.phi[k] = d[12 + PHI_W * k +: PHI_W];
         if (phi_pending.size() == 0) begin
            $display("%0t unexpected result beat: expected none, actual %h", $time, d);
            errors++;
            return;
         end
         want = phi_pending.pop_front();
         check_field("out_x", PHI_W'(want.out_x), PHI_W'(got.out_x));
         check_field("out_y", PHI_W'(want.out_y), PHI_W'(got.out_y));
         check_field("phi_one_one", want.phi[0], got.phi[0]);
         check_field("phi_one_two", want.phi[1], got.phi[1]);
         check_field("phi_two_one", want.phi[2], got.phi[2]);
         check_field("phi_two_two", want.phi[3], got.phi[3]);
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   phi_tracker_type sb = new();

   bit dens_loaded [CELLS];
   bit pot_loaded [CELLS];
   int cur_w    = DEF_MAX_WIDTH;
   int cur_h    = DEF_MAX_HEIGHT;
   bit idle_on  = 1'b1;
   bit hold_rsp = 1'b0;

   pair_field_grid_convolution dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready === 1'b1) sb.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready === 1'b1)
            sb.take_request(req_tuser, req_tdata[5:0], req_tdata[11:6], req_tdata[43:12],
                            req_tdata[75:44], req_tdata[107:76]);
         if (rsp_tvalid === 1'b1 && rsp_tready) sb.match_phi(rsp_tdata);
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = 0;
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall = LONG_HOLD;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 13);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready) ||
             (csr_valid && csr_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_pair_field_grid_convolution NOT OK");
      $finish;
   end

   function automatic logic [VALUE_W-1:0] pick_q16();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      endcase
   endfunction

   function automatic logic [SIZE_REG_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd1;
         default: return 7'($urandom_range(2, 4));
      endcase
   endfunction

   function automatic logic [AREA_W-1:0] pick_area();
      case ($urandom_range(0, 4))
         0: return RST_CELL_AREA;
         1: return $urandom_range(0, 32'h0004_0000);
         2: return $urandom_range(1, 32'h0000_FFFF);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_req(logic [REQ_USER_W-1:0] act, int x, int y, logic [VALUE_W-1:0] v1,
                           logic [VALUE_W-1:0] v2, logic [VALUE_W-1:0] v3);
      int gap;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'd0, v3, v2, v1, y[5:0], x[5:0]};
      if (act == ACT_LOAD_DENSITY) dens_loaded[y * DEF_MAX_WIDTH + x] = 1'b1;
      if (act == ACT_LOAD_POTENTIAL) pot_loaded[y * DEF_MAX_WIDTH + x] = 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic set_grid(logic [SIZE_REG_W-1:0] w, logic [SIZE_REG_W-1:0] h, logic wx,
                           logic wy, logic [AREA_W-1:0] area);
      csr_write(CSR_GRID_WIDTH, {25'd0, w});
      csr_write(CSR_GRID_HEIGHT, {25'd0, h});
      csr_write(CSR_WALL_X, {31'd0, wx});
      csr_write(CSR_WALL_Y, {31'd0, wy});
      csr_write(CSR_CELL_AREA, area);
      // unmapped index, must leave the settings alone
      csr_write(CSR_SPARE + 3'($urandom_range(0, 2)), $urandom);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_w = sb.span(w, DEF_MAX_WIDTH);
      cur_h = sb.span(h, DEF_MAX_HEIGHT);
   endtask

   task automatic await_phi();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.phi_pending.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      await_phi();
      repeat (cur_w * cur_h + 16) @(posedge clock);
   endtask

   // every source cell and table offset of the grid in use that is not yet loaded gets written
   task automatic prime_grid();
      for (int y = 0; y < cur_h; y++) begin
         for (int x = 0; x < cur_w; x++) begin
            if (!dens_loaded[y * DEF_MAX_WIDTH + x])
               send_req(ACT_LOAD_DENSITY, x, y, pick_q16(), pick_q16(), pick_q16());
            if (!pot_loaded[y * DEF_MAX_WIDTH + x])
               send_req(ACT_LOAD_POTENTIAL, x, y, pick_q16(), pick_q16(), pick_q16());
         end
      end
   endtask

   task automatic random_phase(logic [SIZE_REG_W-1:0] w, logic [SIZE_REG_W-1:0] h, logic wx,
                               logic wy, logic [AREA_W-1:0] area, int items, int cap);
      int made, sel, x, y;
      logic [REQ_USER_W-1:0] act;
      made = 0;
      settle();
      set_grid(w, h, wx, wy, area);
      prime_grid();
      for (int k = 0; k < items; k++) begin
         sel = $urandom_range(0, 19);
         if (sel < 9 && made < cap) begin
            made++;
            if ($urandom_range(0, 9) == 0) begin
               x = $urandom_range(0, 63);
               y = $urandom_range(0, 63);
            end else begin
               x = $urandom_range(0, cur_w - 1);
               y = $urandom_range(0, cur_h - 1);
            end
            send_req(ACT_COMPUTE, x, y, $urandom, $urandom, $urandom);
         end else if (sel == 19) begin
            send_req(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                     $urandom, $urandom);
         end else begin
            act = sel[0] ? ACT_LOAD_POTENTIAL : ACT_LOAD_DENSITY;
            if ($urandom_range(0, 1) == 1) begin
               x = $urandom_range(0, cur_w - 1);
               y = $urandom_range(0, cur_h - 1);
            end else begin
               x = $urandom_range(0, 63);
               y = $urandom_range(0, 63);
            end
            send_req(act, x, y, pick_q16(), pick_q16(), pick_q16());
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero width counts as one cell; full-scale area drives both rails
      set_grid(7'd0, 7'd1, 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_req(ACT_LOAD_DENSITY, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_req(ACT_LOAD_POTENTIAL, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_req(ACT_COMPUTE, 0, 0, '0, '0, '0);
      send_req(ACT_COMPUTE, 1, 0, '1, '1, '1);
      send_req(ACT_COMPUTE, 63, 63, '1, '1, '1);
      send_req(ACT_UNUSED, 63, 63, '1, '1, '1);
      send_req(ACT_LOAD_DENSITY, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, '1);
      send_req(ACT_COMPUTE, 0, 0, '1, '0, '1);
      settle();
      set_grid(7'd3, 7'd2, 1'b1, 1'b0, RST_CELL_AREA);
      prime_grid();
      send_req(ACT_COMPUTE, 2, 1, '0, '0, '0);
      send_req(ACT_COMPUTE, 0, 0, '0, '0, '0);
      send_req(ACT_LOAD_DENSITY, 63, 63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
      send_req(ACT_LOAD_POTENTIAL, 63, 63, '0, '0, '0);
      send_req(ACT_LOAD_POTENTIAL, 2, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_req(ACT_COMPUTE, 1, 1, '0, '0, '0);
      send_req(ACT_COMPUTE, 3, 0, '0, '0, '0);
      send_req(ACT_COMPUTE, 0, 2, '0, '0, '0);

      random_phase(pick_size(), pick_size(), 1'($urandom), 1'($urandom), pick_area(), 12, 6);
      random_phase(7'd1, 7'd4, 1'b0, 1'b1, $urandom, 10, 5);
      random_phase(7'd4, 7'd1, 1'b0, 1'b0, 32'h0, 10, 5);
      random_phase(7'd4, 7'd4, 1'b1, 1'b1, pick_area(), 10, 4);
      idle_on = 1'b0;
      random_phase(pick_size(), pick_size(), 1'($urandom), 1'($urandom), pick_area(), 10, 5);
      idle_on = 1'b1;
      random_phase(pick_size(), pick_size(), 1'($urandom), 1'($urandom), pick_area(), 10, 5);

      // result side held off while computes keep coming: output register fills up
      settle();
      set_grid(7'd4, 7'd4, 1'b1, 1'b0, RST_CELL_AREA);
      prime_grid();
      hold_rsp = 1'b1;
      repeat (8) send_req(ACT_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom,
                          $urandom, $urandom);
      await_phi();

      idle_on = 1'b0;
      random_phase(pick_size(), pick_size(), 1'($urandom), 1'($urandom), pick_area(), 16, 8);
      settle();

      if (sb.errors == 0)
         $display("tb_pair_field_grid_convolution OK");
      else
         $display("tb_pair_field_grid_convolution NOT OK");
      $finish;
   end

endmodule

@@ pair_field_grid_convolution.f @@
+incdir+src
src/pfgc_pkg.sv
src/pfgc_ram.sv
src/pfgc_seq.sv
src/pfgc_mac.sv
src/pair_field_grid_convolution.sv
bench/tb_pair_field_grid_convolution.sv
